@@ hdl/running_median_tracker_assert.svh @@
// assertion macros for the running median tracker
// no dependencies; included by the top level
`ifndef RUNNING_MEDIAN_TRACKER_ASSERT_SVH
`define RUNNING_MEDIAN_TRACKER_ASSERT_SVH

// same-cycle implication under reset
`define RMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rmt assertion failed");

// next-cycle implication under reset
`define RMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rmt assertion failed");

`endif

@@ hdl/rmt_pkg.sv @@
// shared types and constants for the running median tracker
// no dependencies
`default_nettype none

package rmt_pkg;

    localparam int VALUE_W = 31;
    localparam int CHAN_W  = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_row_status;

endpackage

`default_nettype wire

@@ hdl/rmt_cell.sv @@
// one sorted cell: holds a value, compares it with the new value,
// takes the left neighbor's value or the new value on insert; uses rmt_pkg
`default_nettype none

module rmt_cell
    import rmt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_shift,
    input  wire logic               i_empty,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic [VALUE_W-1:0] i_left_value,
    input  wire logic               i_left_gt,
    output logic      [VALUE_W-1:0] o_value,
    output logic                    o_gt
);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;

    // empty cells act as +infinity
    assign o_gt    = i_empty || (r_value > i_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_shift && o_gt) begin
            n_value = i_left_gt ? i_left_value : i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

@@ hdl/rmt_row.sv @@
// one channel: a chain of sorted cells plus the fill count,
// and selection of the two middle values; uses rmt_pkg and rmt_cell
`default_nettype none

module rmt_row
    import rmt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_insert,
    input  wire logic [VALUE_W-1:0] i_value,
    output t_row_status             o_status,
    output logic      [VALUE_W-1:0] o_lo,
    output logic      [VALUE_W-1:0] o_hi
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   w_hi_idx;
    logic [CNT_W-1:0]   w_lo_idx;
    logic               w_full;
    logic               w_shift;
    logic [VALUE_W-1:0] w_val [CAPACITY];
    logic               w_gt  [CAPACITY];

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_shift = i_insert && !w_full;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic               w_empty;
            logic [VALUE_W-1:0] w_left_value;
            logic               w_left_gt;

            assign w_empty = (CNT_W'(i) >= r_count);
            if (i == 0) begin : g_first
                assign w_left_value = i_value;
                assign w_left_gt    = 1'b0;
            end else begin : g_rest
                assign w_left_value = w_val[i-1];
                assign w_left_gt    = w_gt[i-1];
            end

            rmt_cell u_cell (
                .i_clk        (i_clk),
                .i_shift      (w_shift),
                .i_empty      (w_empty),
                .i_value      (i_value),
                .i_left_value (w_left_value),
                .i_left_gt    (w_left_gt),
                .o_value      (w_val[i]),
                .o_gt         (w_gt[i])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_shift) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // middle positions of the current count
    assign w_hi_idx = r_count >> 1;
    assign w_lo_idx = r_count[0] ? w_hi_idx : (w_hi_idx - CNT_W'(1));

    always_comb begin
        o_lo = '0;
        o_hi = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CNT_W'(k) == w_lo_idx) begin
                o_lo = o_lo | w_val[k];
            end
            if (CNT_W'(k) == w_hi_idx) begin
                o_hi = o_hi | w_val[k];
            end
        end
    end

    assign o_status.full     = w_full;
    assign o_status.nonempty = (r_count != '0);

endmodule

`default_nettype wire

@@ hdl/running_median_tracker.sv @@
// a request is taken in idle; its result is registered when the done state finds the output slot free
// each request passes through idle, insert, read and done; a new request is taken only back in idle
// the insert state shifts the addressed channel's cell chain for an insert into a channel that is not full;
// the read state selects the middle pair; reset: synchronous active low, clears all fill counts and the output valid
// stored values are not cleared; only entries below a channel's count are read
`default_nettype none

module running_median_tracker
    import rmt_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_op,
    input  wire logic [CHAN_W-1:0]  i_channel,
    input  wire logic [VALUE_W-1:0] i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [VALUE_W-1:0] o_median,
    output logic                    o_has_value,
    output logic                    o_full_dropped
);

`include "running_median_tracker_assert.svh"

    t_state             r_state;
    t_state             n_state;
    logic               r_op;
    logic [CHAN_W-1:0]  r_chan;
    logic               r_chan_ok;
    logic [VALUE_W-1:0] r_value;
    logic               r_drop;
    logic               r_has;
    logic [VALUE_W-1:0] r_lo;
    logic [VALUE_W-1:0] r_hi;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_median;
    logic               r_out_has;
    logic               r_out_drop;

    logic               w_accept;
    logic               w_slot_free;
    logic               w_load_out;
    logic               w_do_insert;
    logic               w_sel_full;
    logic               w_sel_has;
    logic [VALUE_W-1:0] w_sel_lo;
    logic [VALUE_W-1:0] w_sel_hi;
    logic [VALUE_W:0]   w_sum;
    logic [CHANNELS-1:0] w_hit;
    t_row_status        w_status [CHANNELS];
    logic [VALUE_W-1:0] w_lo     [CHANNELS];
    logic [VALUE_W-1:0] w_hi     [CHANNELS];

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++) begin : g_row
            assign w_hit[c] = r_chan_ok && (32'(r_chan) == c);

            rmt_row #(
                .CAPACITY (CAPACITY)
            ) u_row (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_insert (w_do_insert && w_hit[c]),
                .i_value  (r_value),
                .o_status (w_status[c]),
                .o_lo     (w_lo[c]),
                .o_hi     (w_hi[c])
            );
        end
    endgenerate

    always_comb begin
        w_sel_full = 1'b0;
        w_sel_has  = 1'b0;
        w_sel_lo   = '0;
        w_sel_hi   = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            if (w_hit[k]) begin
                w_sel_full = w_sel_full | w_status[k].full;
                w_sel_has  = w_sel_has  | w_status[k].nonempty;
                w_sel_lo   = w_sel_lo   | w_lo[k];
                w_sel_hi   = w_sel_hi   | w_hi[k];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: n_state = ST_READ;
            ST_READ:   n_state = ST_DONE;
            ST_DONE: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        w_do_insert = (r_state == ST_INSERT) && (r_op == OP_INSERT);
        w_load_out  = (r_state == ST_DONE) && w_slot_free;
    end

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_sum       = {1'b0, r_lo} + {1'b0, r_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chan_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_has   <= 1'b0;
            r_out_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_chan_ok <= (32'(i_channel) < CHANNELS);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_out_has   <= r_has;
                r_out_drop  <= r_drop;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_op;
            r_chan  <= i_channel;
            r_value <= i_value;
        end
        if (r_state == ST_INSERT) begin
            r_drop <= w_do_insert && w_sel_full;
        end
        if (r_state == ST_READ) begin
            r_has <= w_sel_has;
            r_lo  <= w_sel_has ? w_sel_lo : '0;
            r_hi  <= w_sel_has ? w_sel_hi : '0;
        end
        if (w_load_out) begin
            r_median <= w_sum[VALUE_W:1];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median       = r_median;
    assign o_has_value    = r_out_has;
    assign o_full_dropped = r_out_drop;

    `RMT_ASSERT_NOW(a_drop_has_value, i_clk, i_rst_n, o_out_valid && o_full_dropped, o_has_value)
    `RMT_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_has_value, o_median == '0)
    `RMT_ASSERT_NOW(a_hit_onehot, i_clk, i_rst_n, 1'b1, $onehot0(w_hit))
    `RMT_ASSERT_NEXT(a_accept_insert, i_clk, i_rst_n, w_accept, r_state == ST_INSERT)

endmodule

`default_nettype wire
